// ===== rtl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// MD5 package
// Shared constants, round tables and the command and status bundles that pass
// between the MD5 controller and datapath.
// ----------------------------------------------------------------------------
package md5_pkg;

	// Initial chaining value, words A to D.
	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;

	// Padding marker byte and the first byte position of the length field.
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam int LEN_POS = 56;

	// Which padded block a compression belongs to.
	typedef enum logic [1:0] {
		MODE_DATA  = 2'd0,
		MODE_WRAP  = 2'd1,
		MODE_FINAL = 2'd2
	} mode_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic absorb;     // store the incoming word and advance the bit count
		logic pad_tail;   // marker byte, zero fill, and length when it fits
		logic pad_len;    // zero fill of a whole block plus the length field
		logic comp_start; // load the working registers from the chaining value
		logic round_en;   // run one compression round
		logic comp_add;   // fold the working registers into the chaining value
		logic emit;       // load the output register and restart the message
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;       // the next byte position is the last of the block
		logic wrap;       // the length field does not fit after the marker
		logic round_last; // the current round is the final one
		logic out_busy;   // the output register holds a word not yet taken
	} sts_t;

	// Additive constant of round i.
	function automatic logic [31:0] round_const(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	// Left rotation amount of round i.
	function automatic logic [4:0] rot_amount(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
			4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/md5_msg_if.sv =====
// ----------------------------------------------------------------------------
// MD5 message channel
// Valid/ready channel that carries one message byte word per handshake.
// ----------------------------------------------------------------------------
interface md5_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       is_last;

	modport source (output valid, output data_byte, output byte_present, output is_last,
		input ready);
	modport sink (input valid, input data_byte, input byte_present, input is_last,
		output ready);
endinterface

// ===== rtl/md5_digest_if.sv =====
// ----------------------------------------------------------------------------
// MD5 digest channel
// Valid/ready channel that carries one 128-bit digest word per handshake.
// ----------------------------------------------------------------------------
interface md5_digest_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_low;
	logic [63:0] digest_high;

	modport source (output valid, output digest_low, output digest_high, input ready);
	modport sink (input valid, input digest_low, input digest_high, output ready);
endinterface

// ===== rtl/md5_dp.sv =====
// ----------------------------------------------------------------------------
// MD5 datapath
// Block buffer, bit count, chaining value, one-round-per-cycle compression
// unit and the digest output register.
// ----------------------------------------------------------------------------
module md5_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  md5_pkg::cmd_t     cmd,
	output md5_pkg::sts_t     sts,
	input  logic [7:0]        data_byte,
	md5_digest_if.source      digest
);
	import md5_pkg::*;

	logic [15:0][3:0][7:0] blk_q;
	logic [63:0]           count_q;
	logic [31:0]           cv_a_q, cv_b_q, cv_c_q, cv_d_q;
	logic [31:0]           a_q, b_q, c_q, d_q;
	logic [5:0]            rnd_q;
	logic                  out_valid_q;
	logic [63:0]           out_low_q, out_high_q;

	logic [5:0]  pos;
	logic [31:0] f_val, m_word, sum, rot_val;
	logic [3:0]  m_idx;
	logic [63:0] rot_wide;

	// Byte position of the next message byte inside the block.
	assign pos = count_q[8:3];

	assign sts.full       = (pos == 6'd63);
	assign sts.wrap       = (pos >= 6'(LEN_POS));
	assign sts.round_last = (rnd_q == 6'd63);
	assign sts.out_busy   = out_valid_q & ~digest.ready;

	// Block buffer: message bytes, then padding and the length field.
	always_ff @(posedge clk) begin
		for (int w = 0; w < 16; w++) begin
			for (int b = 0; b < 4; b++) begin
				if (cmd.absorb && pos == 6'(4 * w + b)) begin
					blk_q[w][b] <= data_byte;
				end else if (cmd.pad_tail) begin
					if (pos == 6'(4 * w + b)) begin
						blk_q[w][b] <= PAD_MARK;
					end else if (6'(4 * w + b) > pos) begin
						if (!sts.wrap && (4 * w + b) >= LEN_POS) begin
							blk_q[w][b] <= count_q[8 * (b + 4 * (w % 2)) +: 8];
						end else begin
							blk_q[w][b] <= 8'h00;
						end
					end
				end else if (cmd.pad_len) begin
					if ((4 * w + b) >= LEN_POS) begin
						blk_q[w][b] <= count_q[8 * (b + 4 * (w % 2)) +: 8];
					end else begin
						blk_q[w][b] <= 8'h00;
					end
				end
			end
		end
	end

	// Round function and message word select.
	always_comb begin
		case (rnd_q[5:4])
			2'd0: begin
				f_val = (b_q & c_q) | (~b_q & d_q);
				m_idx = rnd_q[3:0];
			end
			2'd1: begin
				f_val = (b_q & d_q) | (c_q & ~d_q);
				m_idx = 4'(rnd_q[3:0] * 4'd5 + 4'd1);
			end
			2'd2: begin
				f_val = b_q ^ c_q ^ d_q;
				m_idx = 4'(rnd_q[3:0] * 4'd3 + 4'd5);
			end
			default: begin
				f_val = c_q ^ (b_q | ~d_q);
				m_idx = 4'(rnd_q[3:0] * 4'd7);
			end
		endcase
		m_word   = blk_q[m_idx];
		sum      = a_q + f_val + round_const(rnd_q) + m_word;
		rot_wide = {sum, sum} << rot_amount(rnd_q);
		rot_val  = rot_wide[63:32];
	end

	// Working registers of the compression.
	always_ff @(posedge clk) begin
		if (cmd.comp_start) begin
			a_q <= cv_a_q;
			b_q <= cv_b_q;
			c_q <= cv_c_q;
			d_q <= cv_d_q;
		end else if (cmd.round_en) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + rot_val;
		end
	end

	// Round counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
		end else if (cmd.comp_start) begin
			rnd_q <= '0;
		end else if (cmd.round_en) begin
			rnd_q <= rnd_q + 6'd1;
		end
	end

	// Chaining value and bit count; both restart when the digest is loaded into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_a_q  <= INIT_A;
			cv_b_q  <= INIT_B;
			cv_c_q  <= INIT_C;
			cv_d_q  <= INIT_D;
			count_q <= '0;
		end else if (cmd.emit) begin
			cv_a_q  <= INIT_A;
			cv_b_q  <= INIT_B;
			cv_c_q  <= INIT_C;
			cv_d_q  <= INIT_D;
			count_q <= '0;
		end else begin
			if (cmd.comp_add) begin
				cv_a_q <= cv_a_q + a_q;
				cv_b_q <= cv_b_q + b_q;
				cv_c_q <= cv_c_q + c_q;
				cv_d_q <= cv_d_q + d_q;
			end
			if (cmd.absorb) begin
				count_q <= count_q + 64'd8;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (digest.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_low_q  <= {cv_b_q, cv_a_q};
			out_high_q <= {cv_d_q, cv_c_q};
		end
	end

	assign digest.valid       = out_valid_q;
	assign digest.digest_low  = out_low_q;
	assign digest.digest_high = out_high_q;

endmodule

// ===== rtl/md5_ctrl.sv =====
// ----------------------------------------------------------------------------
// MD5 controller
// Sequences byte intake, block compression, padding and digest output.
// ----------------------------------------------------------------------------
module md5_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          msg_valid,
	input  logic          byte_present,
	input  logic          is_last,
	output logic          msg_ready,
	input  md5_pkg::sts_t sts,
	output md5_pkg::cmd_t cmd
);
	import md5_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ROUND = 6'b000010,
		S_ADD   = 6'b000100,
		S_PAD   = 6'b001000,
		S_PAD2  = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;
	logic   last_q, last_d;

	// Next state and command decode.
	always_comb begin
		state_d   = state_q;
		mode_d    = mode_q;
		last_d    = last_q;
		cmd       = '0;
		msg_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				msg_ready = 1'b1;
				if (msg_valid) begin
					cmd.absorb = byte_present;
					if (byte_present && sts.full) begin
						cmd.comp_start = 1'b1;
						mode_d         = MODE_DATA;
						last_d         = is_last;
						state_d        = S_ROUND;
					end else if (is_last) begin
						state_d = S_PAD;
					end
				end
			end
			S_ROUND: begin
				cmd.round_en = 1'b1;
				if (sts.round_last) begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				cmd.comp_add = 1'b1;
				case (mode_q)
					MODE_DATA:  state_d = last_q ? S_PAD : S_IDLE;
					MODE_WRAP:  state_d = S_PAD2;
					MODE_FINAL: state_d = S_EMIT;
					default:    state_d = S_IDLE;
				endcase
			end
			S_PAD: begin
				cmd.pad_tail   = 1'b1;
				cmd.comp_start = 1'b1;
				mode_d         = sts.wrap ? MODE_WRAP : MODE_FINAL;
				state_d        = S_ROUND;
			end
			S_PAD2: begin
				cmd.pad_len    = 1'b1;
				cmd.comp_start = 1'b1;
				mode_d         = MODE_FINAL;
				state_d        = S_ROUND;
			end
			S_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= MODE_DATA;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			last_q  <= last_d;
		end
	end

endmodule

// ===== rtl/md5_stream_hasher.sv =====
// A word that neither fills a block nor ends the message leaves intake ready for the next word.
// A word that fills the block holds intake during the 64 rounds and the fold of its block.
// After a last word, each padded block takes a padding step, then the rounds and the fold;
// then the digest register is loaded once it is free. Two padded blocks are needed when
// the length field does not fit after the marker. No bytes are taken while a block compresses.
// Reset (arst_n low) restores the initial chaining value and clears the bit count.
// ----------------------------------------------------------------------------
// MD5 stream hasher
// Takes message bytes one word at a time and returns the 128-bit MD5 digest
// of each message after its last word.
// ----------------------------------------------------------------------------
module md5_stream_hasher (
	input  logic          clk,
	input  logic          arst_n,
	md5_msg_if.sink       msg,
	md5_digest_if.source  digest
);
	import md5_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Control sequencer.
	md5_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg.valid),
		.byte_present (msg.byte_present),
		.is_last      (msg.is_last),
		.msg_ready    (msg.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// Hash datapath with the output register.
	md5_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.data_byte (msg.data_byte),
		.digest    (digest)
	);

endmodule
